/* rtl/core/decimal_to_roman_encoder_assert.svh */
// assertion macros shared by the roman numeral encoder modules
`ifndef DECIMAL_TO_ROMAN_ENCODER_ASSERT_SVH
`define DECIMAL_TO_ROMAN_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define D2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define D2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/d2r_pkg.sv */
// types, constants and the numeral table of the roman numeral encoder
`default_nettype none

package d2r_pkg;

  // field widths
  localparam int VAL_W = 12;
  localparam int LET_W = 7;

  // largest value that has a numeral
  localparam logic [VAL_W-1:0] MAX_VALUE = 12'd3999;

  // numeral table
  localparam int NENT  = 13;
  localparam int ENT_W = $clog2(NENT);

  // queue between front and back, depth is a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ascii letters
  localparam logic [LET_W-1:0] CH_NONE = 7'h00;
  localparam logic [LET_W-1:0] CH_I    = 7'h49;
  localparam logic [LET_W-1:0] CH_V    = 7'h56;
  localparam logic [LET_W-1:0] CH_X    = 7'h58;
  localparam logic [LET_W-1:0] CH_L    = 7'h4C;
  localparam logic [LET_W-1:0] CH_C    = 7'h43;
  localparam logic [LET_W-1:0] CH_D    = 7'h44;
  localparam logic [LET_W-1:0] CH_M    = 7'h4D;

  // weights in descending order
  localparam logic [VAL_W-1:0] WEIGHT [NENT] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };

  // leading letter of each entry
  localparam logic [LET_W-1:0] FIRST [NENT] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };

  // trailing letter of subtractive pairs, none for single letters
  localparam logic [LET_W-1:0] SECOND [NENT] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  // classified job handed from front to back
  typedef struct packed {
    logic             err;
    logic [VAL_W-1:0] value;
  } job_t;

endpackage

`default_nettype wire

/* rtl/core/d2r_if.sv */
// valid/ready channels for the input words and the letter words
`default_nettype none

interface d2r_in_if;
  logic                       valid;
  logic                       ready;
  logic [d2r_pkg::VAL_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface d2r_out_if;
  logic                       valid;
  logic                       ready;
  logic [d2r_pkg::LET_W-1:0]  letter;
  logic                       last;
  logic                       error;

  modport source (output valid, output letter, output last, output error, input ready);
  modport sink   (input valid, input letter, input last, input error, output ready);
endinterface

`default_nettype wire

/* rtl/core/d2r_front.sv */
// front end: takes input words and flags values that have no numeral
`default_nettype none

module d2r_front (
  input  wire logic                      in_valid,
  input  wire logic [d2r_pkg::VAL_W-1:0] in_value,
  output logic                           in_ready,
  input  wire logic                      q_full,
  output logic                           push,
  output d2r_pkg::job_t                  push_job
);

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // range check: zero and values above the largest numeral are errors
  always_comb begin
    push_job.value = in_value;
    push_job.err   = (in_value == '0) || (in_value > d2r_pkg::MAX_VALUE);
  end

endmodule

`default_nettype wire

/* rtl/core/d2r_queue.sv */
// short queue of classified jobs between front and back
`default_nettype none

`include "decimal_to_roman_encoder_assert.svh"

module d2r_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire d2r_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output d2r_pkg::job_t      head_job
);

  d2r_pkg::job_t                 mem_r [d2r_pkg::QDEPTH];
  logic [d2r_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [d2r_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [d2r_pkg::QCNT_W-1:0]    count_r, count_nxt;

  // status
  assign full       = (count_r == d2r_pkg::QCNT_W'(d2r_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // pointer and count update, pointers wrap at the power-of-two depth
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // no overflow, no underflow
  `D2R_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push, "push into full queue")
  `D2R_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/core/d2r_back.sv */
// back end: greedy numeral walk, one letter word per cycle into the output register unless the output stalls
`default_nettype none

`include "decimal_to_roman_encoder_assert.svh"

module d2r_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      head_valid,
  input  wire d2r_pkg::job_t             head_job,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [d2r_pkg::LET_W-1:0]      out_letter,
  output logic                           out_last,
  output logic                           out_error
);

  // job in progress
  logic                          busy_r, busy_nxt;
  logic                          sec_r, sec_nxt;
  logic [d2r_pkg::LET_W-1:0]     sec_let_r, sec_let_nxt;
  logic [d2r_pkg::VAL_W-1:0]     rest_r, rest_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [d2r_pkg::LET_W-1:0]     letter_r, letter_nxt;
  logic                          last_r, last_nxt;
  logic                          error_r, error_nxt;

  logic                          step;
  logic                          working;
  logic                          cur_err;
  logic [d2r_pkg::VAL_W-1:0]     cur_rest;
  logic [d2r_pkg::ENT_W-1:0]     sel;
  logic [d2r_pkg::VAL_W-1:0]     diff;
  logic                          pair;

  assign out_valid  = out_valid_r;
  assign out_letter = letter_r;
  assign out_last   = last_r;
  assign out_error  = error_r;

  // output register free or being emptied this cycle
  assign step    = !out_valid_r || out_ready;
  assign working = busy_r || head_valid;

  // a fresh job is worked on directly from the queue head
  assign cur_rest = busy_r ? rest_r : head_job.value;
  assign cur_err  = !busy_r && head_job.err;

  // largest table entry that fits the remainder
  always_comb begin
    sel = d2r_pkg::ENT_W'(d2r_pkg::NENT - 1);
    for (int i = d2r_pkg::NENT - 1; i >= 0; i--) begin
      if (cur_rest >= d2r_pkg::WEIGHT[i]) begin
        sel = d2r_pkg::ENT_W'(i);
      end
    end
  end

  assign diff = cur_rest - d2r_pkg::WEIGHT[sel];
  assign pair = (d2r_pkg::SECOND[sel] != d2r_pkg::CH_NONE);

  // next letter and job state
  always_comb begin
    busy_nxt      = busy_r;
    sec_nxt       = sec_r;
    sec_let_nxt   = sec_let_r;
    rest_nxt      = rest_r;
    out_valid_nxt = out_valid_r;
    letter_nxt    = letter_r;
    last_nxt      = last_r;
    error_nxt     = error_r;
    pop           = 1'b0;
    if (step) begin
      out_valid_nxt = working;
      if (working) begin
        pop = !busy_r;
        priority if (cur_err) begin
          letter_nxt = d2r_pkg::CH_NONE;
          last_nxt   = 1'b1;
          error_nxt  = 1'b1;
          busy_nxt   = 1'b0;
          sec_nxt    = 1'b0;
        end else if (busy_r && sec_r) begin
          letter_nxt = sec_let_r;
          last_nxt   = (rest_r == '0);
          error_nxt  = 1'b0;
          busy_nxt   = (rest_r != '0);
          sec_nxt    = 1'b0;
        end else begin
          letter_nxt  = d2r_pkg::FIRST[sel];
          last_nxt    = !pair && (diff == '0);
          error_nxt   = 1'b0;
          rest_nxt    = diff;
          sec_nxt     = pair;
          sec_let_nxt = d2r_pkg::SECOND[sel];
          busy_nxt    = pair || (diff != '0);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sec_let_r <= sec_let_nxt;
    rest_r    <= rest_nxt;
    letter_r  <= letter_nxt;
    last_r    <= last_nxt;
    error_r   <= error_nxt;
  end

  // error word is a lone final word with no letter
  `D2R_ASSERT_IMP(a_err_word, clk, rst_n, out_valid_r && error_r,
    last_r && (letter_r == d2r_pkg::CH_NONE), "error word malformed")
  // a job in progress still has letters to give
  `D2R_ASSERT_IMP(a_busy_rest, clk, rst_n, busy_r && !sec_r, rest_r != '0,
    "busy with nothing left")
  // a pending second letter belongs to a job in progress
  `D2R_ASSERT_IMP(a_sec_busy, clk, rst_n, sec_r, busy_r, "second letter while idle")
  // a last word ends the job
  `D2R_ASSERT_NXT(a_last_idle, clk, rst_n, step && working && last_nxt, !busy_r,
    "job still busy after last word")

endmodule

`default_nettype wire

/* rtl/core/decimal_to_roman_encoder.sv */
// top level of the roman numeral encoder
`default_nettype none

// Converts each input word (value 1 to 3999) into its Roman numeral, sent as one
// ASCII letter per output word with last set on the final letter; a value of 0 or
// above 3999 gives a single word with error and last set and letter 0. A valid
// value gives 1 to 15 letter words (15 for 3888), an error value one word: the
// back end picks the largest fitting table entry and loads one letter into the
// output register each cycle it is free or emptied. A two-entry queue between the
// input side and the back end lets new words be taken while a numeral is being
// sent, and the output register is reloaded in the same cycle its word is taken.
module decimal_to_roman_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  d2r_in_if.sink    in_ch,
  d2r_out_if.source out_ch
);

  logic          q_full;
  logic          push;
  d2r_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  d2r_pkg::job_t head_job;

  // classify incoming words
  d2r_front u_front (
    .in_valid (in_ch.valid),
    .in_value (in_ch.value),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  d2r_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // letter generation
  d2r_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_letter (out_ch.letter),
    .out_last   (out_ch.last),
    .out_error  (out_ch.error)
  );

endmodule

`default_nettype wire

/* verif/decimal_to_roman_encoder_tb.sv */
// self-checking testbench for the roman numeral encoder: directed and random values
`timescale 1ns / 100ps

module decimal_to_roman_encoder_tb;

  // one letter word as it leaves the block
  typedef struct packed {
    logic [d2r_pkg::LET_W-1:0] letter;
    logic                      last;
    logic                      error;
  } letter_word_t;

  localparam int NUM_SYMS     = 13;
  localparam int RANDOM_ITEMS = 340;
  localparam int DRAIN_CYCLES = 40;

  // greedy numeral table, largest weight first
  localparam int    SYM_WEIGHT [NUM_SYMS] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9,
                                              5, 4, 1};
  localparam string SYM_TEXT   [NUM_SYMS] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL",
                                              "X", "IX", "V", "IV", "I"};

  logic clk;
  logic rst_n;

  d2r_in_if  in_ch ();
  d2r_out_if out_ch ();

  letter_word_t pending_letters [$];

  int  fail_count    = 0;
  int  words_checked = 0;
  int  values_sent   = 0;
  int  bad_values    = 0;
  bit  idle_en       = 1'b1;

  decimal_to_roman_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // expected letter words for one input value
  function automatic void predict_numeral(logic [d2r_pkg::VAL_W-1:0] value);
    letter_word_t word;
    letter_word_t numeral [$];
    int rest;
    rest = int'(value);
    if (rest == 0 || rest > 3999) begin
      word.letter = '0;
      word.last   = 1'b1;
      word.error  = 1'b1;
      pending_letters.push_back(word);
      return;
    end
    for (int s = 0; s < NUM_SYMS; s++) begin
      while (rest >= SYM_WEIGHT[s]) begin
        for (int c = 0; c < SYM_TEXT[s].len(); c++) begin
          word.letter = d2r_pkg::LET_W'(SYM_TEXT[s][c]);
          word.last   = 1'b0;
          word.error  = 1'b0;
          numeral.push_back(word);
        end
        rest -= SYM_WEIGHT[s];
      end
    end
    numeral[numeral.size()-1].last = 1'b1;
    foreach (numeral[k]) pending_letters.push_back(numeral[k]);
  endfunction

  // send one value word, optionally after a random gap; valid stays high on return
  task automatic send_value(logic [d2r_pkg::VAL_W-1:0] value);
    int gap;
    gap = (idle_en && $urandom_range(0, 1)) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predict_numeral(value);
    values_sent++;
    if (value == 0 || value > 3999) bad_values++;
  endtask

  // sink side: ready bursts and stalls
  initial begin : ready_drive
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      if (!idle_en) begin
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // check each accepted letter word against the oldest expectation
  always @(posedge clk) begin : letter_check
    letter_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_letters.size() == 0) begin
        $display("%0t: unexpected word letter=%h last=%b error=%b", $time,
                 out_ch.letter, out_ch.last, out_ch.error);
        fail_count++;
      end else begin
        want = pending_letters.pop_front();
        words_checked++;
        if (out_ch.letter !== want.letter) begin
          $display("%0t: letter expected %h actual %h", $time, want.letter, out_ch.letter);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.error !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, out_ch.error);
          fail_count++;
        end
      end
    end
  end

  // range limits and out-of-range values
  task automatic test_range_limits();
    send_value(12'd1);
    send_value(12'd3999);
    send_value(12'd0);
    send_value(12'd4000);
    send_value(12'd4095);
    send_value(12'd2048);
    send_value(12'd1000);
  endtask

  // every subtractive pair and every single letter
  task automatic test_subtractive_pairs();
    send_value(12'd4);
    send_value(12'd9);
    send_value(12'd40);
    send_value(12'd90);
    send_value(12'd400);
    send_value(12'd900);
    send_value(12'd1994);
    send_value(12'd1666);
    send_value(12'd444);
  endtask

  // longest numerals with no idling on either side
  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_value(12'd3888);
    send_value(12'd2888);
    send_value(12'd0);
    send_value(12'd3888);
    send_value(12'd5);
    send_value(12'd3000);
    idle_en = 1'b1;
  endtask

  // random values, mostly in range, with bursts of back-to-back traffic
  task automatic test_random_values();
    logic [d2r_pkg::VAL_W-1:0] value;
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 80 == 40) idle_en = 1'b0;
      if (n % 80 == 60) idle_en = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        value = d2r_pkg::VAL_W'($urandom_range(1, 3999));
      end else if (pick < 65) begin
        // long numerals built from digits near 3 and 8
        value = d2r_pkg::VAL_W'($urandom_range(0, 3) * 1000 + $urandom_range(3, 9) * 100 +
                                $urandom_range(3, 9) * 10 + $urandom_range(3, 9));
        if (value == 0) value = 12'd3888;
      end else if (pick < 80) begin
        value = d2r_pkg::VAL_W'($urandom_range(1, 49));
      end else if (pick < 92) begin
        value = d2r_pkg::VAL_W'($urandom_range(0, 4095));
      end else if (pick < 96) begin
        value = d2r_pkg::VAL_W'($urandom_range(4000, 4095));
      end else begin
        value = '0;
      end
      send_value(value);
    end
  endtask

  // stimulus sequence
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_limits();
    test_subtractive_pairs();
    test_back_to_back();
    test_random_values();
    in_ch.valid <= 1'b0;

    while (pending_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d values, %0d of them out of range", values_sent, bad_values);
    $display("checked %0d letter words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("[decimal_to_roman_encoder] OK");
    end else begin
      $display("[decimal_to_roman_encoder] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("%0t: timeout, %0d words still expected", $time, pending_letters.size());
    $display("[decimal_to_roman_encoder] ERROR");
    $finish;
  end

endmodule
